// ===== hw/rtl/lru_tbl_pkg.sv =====
package lru_tbl_pkg;

	localparam int ADDR_PORT_W = 64;
	localparam int SLOT_PORT_W = 2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WRITE = 4'b1000
	} lru_state_t;

endpackage

// ===== hw/rtl/lru_tbl_if.sv =====
interface lru_req_if import lru_tbl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [ADDR_PORT_W-1:0] lookup_address;

	modport source(output valid, output lookup_address, input ready);
	modport sink(input valid, input lookup_address, output ready);
endinterface

interface lru_rsp_if import lru_tbl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   was_hit;
	logic [SLOT_PORT_W-1:0] slot_used;
	logic                   did_evict;
	logic [ADDR_PORT_W-1:0] evicted_address;

	modport source(output valid, output was_hit, output slot_used, output did_evict,
		output evicted_address, input ready);
	modport sink(input valid, input was_hit, input slot_used, input did_evict,
		input evicted_address, output ready);
endinterface

// ===== hw/rtl/lru_tbl_ram.sv =====
module lru_tbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/lru_tbl_front.sv =====
module lru_tbl_front import lru_tbl_pkg::*; #(
	parameter int ADDR_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lru_req_if.sink               req,
	output logic                  q_valid,
	output logic [ADDR_WIDTH-1:0] q_addr,
	input  logic                  q_pop
);

	// two-entry queue of trimmed addresses
	logic [ADDR_WIDTH-1:0] buf_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  pop;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign pop       = q_pop && q_valid;
	assign q_addr    = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= req.lookup_address[ADDR_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/lru_tbl_engine.sv =====
module lru_tbl_engine import lru_tbl_pkg::*; #(
	parameter int ENTRIES     = 4,
	parameter int ADDR_WIDTH  = 64,
	parameter int STAMP_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [ADDR_WIDTH-1:0] q_addr,
	output logic                  q_pop,
	lru_rsp_if.source             rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	lru_state_t             state_q;
	logic [CNT_W-1:0]       fill_q;
	logic [STAMP_WIDTH-1:0] stamp_cnt_q;
	logic [IDX_W-1:0]       issue_idx_q;
	logic                   chk_vld_s1;
	logic [IDX_W-1:0]       chk_idx_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [STAMP_WIDTH-1:0] min_q;
	logic [IDX_W-1:0]       vic_q;
	logic [ADDR_WIDTH-1:0]  vic_tag_q;
	logic [ADDR_WIDTH-1:0]  addr_q;
	logic                   out_vld_q;

	logic                   full;
	logic [IDX_W-1:0]       last_idx;
	logic                   out_free;
	logic                   start;
	logic                   issue;
	logic [IDX_W-1:0]       rd_addr;
	logic [IDX_W-1:0]       slot;
	logic                   do_write;
	logic                   evict;
	logic [ADDR_WIDTH-1:0]  tag_rd;
	logic [STAMP_WIDTH-1:0] stamp_rd;

	assign full      = (fill_q == CNT_W'(ENTRIES));
	assign last_idx  = IDX_W'(fill_q - 1'b1);
	assign out_free  = !out_vld_q || rsp.ready;
	assign start     = (state_q == ST_IDLE) && q_valid;
	assign q_pop     = start;
	assign issue     = (start && (fill_q != '0)) || (state_q == ST_SCAN);
	assign rd_addr   = (state_q == ST_IDLE) ? '0 : issue_idx_q;
	assign evict     = !hit_q && full;
	assign slot      = hit_q ? hit_idx_q : (full ? vic_q : IDX_W'(fill_q));
	assign do_write  = (state_q == ST_WRITE) && out_free;
	assign rsp.valid = out_vld_q;

	lru_tbl_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(ENTRIES)) u_tag_ram (
		.clk   (clk),
		.we    (do_write && !hit_q),
		.waddr (slot),
		.wdata (addr_q),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	lru_tbl_ram #(.WIDTH(STAMP_WIDTH), .DEPTH(ENTRIES)) u_stamp_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (slot),
		.wdata (stamp_cnt_q),
		.raddr (rd_addr),
		.rdata (stamp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			stamp_cnt_q <= '0;
			issue_idx_q <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			chk_vld_s1 <= issue;
			if (chk_vld_s1 && !hit_q && (tag_rd == addr_q)) begin
				hit_q <= 1'b1;
			end
			if (do_write) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						hit_q       <= 1'b0;
						issue_idx_q <= IDX_W'(1);
						if (stamp_cnt_q != '1) begin
							stamp_cnt_q <= stamp_cnt_q + 1'b1;
						end
						if (fill_q == '0) begin
							state_q <= ST_WRITE;
						end else if (last_idx == '0) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					issue_idx_q <= issue_idx_q + 1'b1;
					if (issue_idx_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						if (!hit_q && !full) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_addr;
		if (start) begin
			addr_q <= q_addr;
		end
		if (chk_vld_s1 && !hit_q && (tag_rd == addr_q)) begin
			hit_idx_q <= chk_idx_s1;
		end
		// ties go to the higher index
		if (chk_vld_s1 && ((chk_idx_s1 == '0) || (stamp_rd <= min_q))) begin
			min_q     <= stamp_rd;
			vic_q     <= chk_idx_s1;
			vic_tag_q <= tag_rd;
		end
		if (do_write) begin
			rsp.was_hit         <= hit_q;
			rsp.slot_used       <= SLOT_PORT_W'(slot);
			rsp.did_evict       <= evict;
			rsp.evicted_address <= evict ? ADDR_PORT_W'(vic_tag_q) : '0;
		end
	end

endmodule

// ===== hw/rtl/lru_address_table.sv =====
// Fully associative address table of ENTRIES slots with LRU replacement by
// access stamp. Each request transaction yields exactly one response
// transaction. In the engine the idle state starts an item and reads entry
// zero, the scan state reads the other valid entries one per cycle over the
// single read port of the tag and stamp memories, the drain state takes the
// last read data, and the write state writes back and loads the response
// register; the write state waits while the response register still holds
// an unaccepted transaction. With one valid entry the scan state is skipped,
// and on an empty table the idle state goes straight to the write state. A
// two-entry request queue and the response register let both sides stall
// independently. No clearing pass is needed after reset. Address bits above
// ADDR_WIDTH are ignored; slot_used holds the low two bits of the slot index.
module lru_address_table import lru_tbl_pkg::*; #(
	parameter int ENTRIES     = 4,
	parameter int ADDR_WIDTH  = 64,
	parameter int STAMP_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lru_req_if.sink   req,
	lru_rsp_if.source rsp
);

	logic                  q_valid;
	logic [ADDR_WIDTH-1:0] q_addr;
	logic                  q_pop;
	logic [2:0]            pend_q;
	logic                  acc_in;
	logic                  acc_out;

	lru_tbl_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_addr  (q_addr),
		.q_pop   (q_pop)
	);

	lru_tbl_engine #(
		.ENTRIES     (ENTRIES),
		.ADDR_WIDTH  (ADDR_WIDTH),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_addr  (q_addr),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

	assign acc_in  = req.valid && req.ready;
	assign acc_out = rsp.valid && rsp.ready;

	// transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else if (acc_in && !acc_out) begin
			pend_q <= pend_q + 3'd1;
		end else if (acc_out && !acc_in) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (pend_q != 3'd0))
		else $error("response without pending request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more transactions in flight than storage");

	a_evict_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.did_evict) |-> (rsp.evicted_address == '0))
		else $error("evicted address set without eviction");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.did_evict) |-> !rsp.was_hit)
		else $error("hit reported with eviction");

endmodule

// ===== verif/tb_lru_address_table.sv =====
module tb_lru_address_table;
	timeunit 1ns;
	timeprecision 1ps;
	import lru_tbl_pkg::*;

	localparam int ENTRIES     = 4;
	localparam int ADDR_WIDTH  = 64;
	localparam int STAMP_WIDTH = 32;
	localparam int STUCK_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 800;
	localparam int STEADY_ITEMS = 150;

	typedef logic [ADDR_PORT_W-1:0] port_addr_t;

	typedef struct packed {
		logic                   was_hit;
		logic [SLOT_PORT_W-1:0] slot_used;
		logic                   did_evict;
		logic [ADDR_PORT_W-1:0] evicted_address;
	} lookup_result_t;

	class lru_lookup_tracker;
		logic [ADDR_WIDTH-1:0]  tags [ENTRIES];
		logic [STAMP_WIDTH-1:0] stamps [ENTRIES];
		int                     fill;
		logic [STAMP_WIDTH-1:0] access_count;
		lookup_result_t         expected_lookups[$];
		int                     mismatches;

		function new();
			foreach (tags[i]) begin
				tags[i]   = '0;
				stamps[i] = '0;
			end
			fill         = 0;
			access_count = '0;
			mismatches   = 0;
		endfunction

		function void note_lookup(port_addr_t raw);
			logic [ADDR_WIDTH-1:0]  addr;
			logic [STAMP_WIDTH-1:0] oldest;
			lookup_result_t         res;
			int                     slot;
			addr = raw[ADDR_WIDTH-1:0];
			res  = '0;
			slot = -1;
			if (access_count != '1)
				access_count++;
			for (int i = 0; i < fill; i++)
				if (slot < 0 && tags[i] == addr)
					slot = i;
			if (slot >= 0) begin
				res.was_hit = 1'b1;
			end else if (fill < ENTRIES) begin
				slot       = fill;
				tags[slot] = addr;
				fill++;
			end else begin
				// LRU victim: smallest stamp, highest index on ties
				slot   = 0;
				oldest = stamps[0];
				for (int i = 1; i < ENTRIES; i++)
					if (stamps[i] <= oldest) begin
						oldest = stamps[i];
						slot   = i;
					end
				res.did_evict       = 1'b1;
				res.evicted_address = ADDR_PORT_W'(tags[slot]);
				tags[slot]          = addr;
			end
			stamps[slot]  = access_count;
			res.slot_used = SLOT_PORT_W'(slot);
			expected_lookups.push_back(res);
		endfunction

		function void check_lookup(lookup_result_t got);
			lookup_result_t want;
			if (expected_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: hit=%0b slot=%0d evict=%0b addr=%h",
						$time, got.was_hit, got.slot_used, got.did_evict, got.evicted_address);
				return;
			end
			want = expected_lookups.pop_front();
			if (got.was_hit !== want.was_hit || got.slot_used !== want.slot_used ||
				got.did_evict !== want.did_evict ||
				got.evicted_address !== want.evicted_address) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] mismatch: exp hit=%0b slot=%0d evict=%0b addr=%h",
						$time, want.was_hit, want.slot_used, want.did_evict,
						want.evicted_address);
					$display("[%0t]           got hit=%0b slot=%0d evict=%0b addr=%h",
						$time, got.was_hit, got.slot_used, got.did_evict,
						got.evicted_address);
				end
			end
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   ready_hold;
	int   stuck_cycles;

	lru_req_if req_bus();
	lru_rsp_if rsp_bus();

	lru_lookup_tracker tracker = new();

	lru_address_table #(
		.ENTRIES    (ENTRIES),
		.ADDR_WIDTH (ADDR_WIDTH),
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	always #5 clk = ~clk;

	// response-side stalls
	always @(negedge clk) begin
		if (steady) begin
			rsp_bus.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			ready_hold = $urandom_range(1, 18);
			rsp_bus.ready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			tracker.check_lookup('{rsp_bus.was_hit, rsp_bus.slot_used, rsp_bus.did_evict,
				rsp_bus.evicted_address});
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic port_addr_t random_address();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic send_lookup(input port_addr_t addr);
		int gap;
		if (!steady && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid          <= 1'b1;
		req_bus.lookup_address <= addr;
		do
			@(posedge clk);
		while (!req_bus.ready);
		tracker.note_lookup(addr);
		@(negedge clk);
	endtask

	task automatic run_random_block(input int count);
		port_addr_t pool[8];
		int         pool_size;
		pool_size = $urandom_range(3, 8);
		foreach (pool[i])
			pool[i] = random_address();
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				send_lookup(random_address());
			else
				send_lookup(pool[$urandom_range(0, pool_size - 1)]);
		end
	endtask

	initial begin
		port_addr_t directed[$];
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		steady                 = 1'b0;
		ready_hold             = 0;
		stuck_cycles           = 0;
		req_bus.valid          = 1'b0;
		req_bus.lookup_address = '0;
		rsp_bus.ready          = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill, hit while filling, hit when full, evictions, back-to-back repeats
		directed = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'h8000_0000_0000_0000, 64'h1, 64'h1, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h8000_0000_0000_0000,
			64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
		foreach (directed[i])
			send_lookup(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n += 40)
			run_random_block(40);
		steady = 1'b1;
		for (int n = 0; n < STEADY_ITEMS; n += 50)
			run_random_block(50);
		req_bus.valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4 * (ENTRIES + 2)) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lru_tbl_pkg.sv
hw/rtl/lru_tbl_if.sv
hw/rtl/lru_tbl_ram.sv
hw/rtl/lru_tbl_front.sv
hw/rtl/lru_tbl_engine.sv
hw/rtl/lru_address_table.sv
verif/tb_lru_address_table.sv
